// ===== sv/iq_dc_blocker_byte_converter_macros.svh =====
// Assertion macros for the I/Q DC blocker and byte converter.
// Expects i_clk and i_rst_n in the scope of each use; no other dependencies.
`ifndef IQ_DC_BLOCKER_BYTE_CONVERTER_MACROS_SVH
`define IQ_DC_BLOCKER_BYTE_CONVERTER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define IQDCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define IQDCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/iqdcb_pkg.sv =====
// Shared types and constants for the I/Q DC blocker and byte converter.
// No dependencies.
`default_nettype none

package iqdcb_pkg;

    localparam int SAMP_W   = 16;
    localparam int EST_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int COEF_W   = 9;
    // Averaging coefficient in Q0.16, about 0.002
    localparam logic [COEF_W-1:0] EMA_COEF = 9'd131;
    // Offset-binary flip of the high byte
    localparam logic [BYTE_W-1:0] BYTE_OFFSET = 8'h80;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DC_EN = 1'b0,
        CFG_WIDE  = 1'b1
    } t_cfg_idx;

    // Control from the top level to each lane
    typedef struct packed {
        logic load;    // item accepted this cycle
        logic enable;  // DC removal on
        logic clear;   // zero the estimate
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== sv/iqdcb_lane.sv =====
// One channel of the DC blocker: running Q16.16 estimate and corrected sample.
// Depends on iqdcb_pkg.
`default_nettype none

module iqdcb_lane (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire iqdcb_pkg::t_lane_ctl    i_ctl,
    input  wire logic signed [15:0]      i_sample,
    output logic signed [15:0]           o_corr
);

    logic signed [31:0] r_est;
    logic signed [15:0] r_x;
    logic signed [31:0] r_e;

    logic signed [32:0] diff;
    logic signed [40:0] prod;
    logic signed [24:0] step;
    logic signed [32:0] n_est;
    logic signed [32:0] d;
    logic signed [32:0] adj;
    logic signed [16:0] t;

    // Estimate update: est += floor((x*65536 - est) * 131 / 65536)
    always_comb begin
        diff  = {i_sample[15], i_sample, 16'h0000} - {r_est[31], r_est};
        prod  = $signed({{8{diff[32]}}, diff}) *
                $signed({32'h0000_0000, iqdcb_pkg::EMA_COEF});
        step  = prod[40:16];
        n_est = {r_est[31], r_est} + {{8{step[24]}}, step};
    end

    // Hold the estimate; zero it on clear, advance it on each item while removal is on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
        end else if (i_ctl.clear) begin
            r_est <= '0;
        end else if (i_ctl.load && i_ctl.enable) begin
            r_est <= n_est[31:0];
        end
    end

    // Capture the sample and its estimate, updated while removal is on, for the correction stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_sample;
            r_e <= i_ctl.enable ? n_est[31:0] : r_est;
        end
    end

    // Subtract, truncate toward zero and saturate to int16
    always_comb begin
        d   = {r_x[15], r_x, 16'h0000} - {r_e[31], r_e};
        adj = d + (d[32] ? 33'sd65535 : 33'sd0);
        t   = adj[32:16];
        if (t[16] != t[15]) begin
            o_corr = t[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            o_corr = t[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/iqdcb_out.sv =====
// Merging stage: combines both lanes into one result item in word or byte form.
// Depends on iqdcb_pkg.
`default_nettype none

module iqdcb_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic               i_wide,
    input  wire logic signed [15:0] i_corr_i,
    input  wire logic signed [15:0] i_corr_q,
    input  wire logic               i_ready,
    output logic                    o_space,
    output logic                    o_valid,
    output logic signed [15:0]      o_word_i,
    output logic signed [15:0]      o_word_q,
    output logic [7:0]              o_byte_i,
    output logic [7:0]              o_byte_q
);

    logic               r_valid;
    logic signed [15:0] r_word_i;
    logic signed [15:0] r_word_q;
    logic [7:0]         r_byte_i;
    logic [7:0]         r_byte_q;

    assign o_space = !r_valid || i_ready;

    // Output item valid: set on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Format the item; the unused form reads zero
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_wide) begin
                r_word_i <= i_corr_i;
                r_word_q <= i_corr_q;
                r_byte_i <= '0;
                r_byte_q <= '0;
            end else begin
                r_word_i <= '0;
                r_word_q <= '0;
                r_byte_i <= i_corr_i[15:8] ^ iqdcb_pkg::BYTE_OFFSET;
                r_byte_q <= i_corr_q[15:8] ^ iqdcb_pkg::BYTE_OFFSET;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_word_i = r_word_i;
    assign o_word_q = r_word_q;
    assign o_byte_i = r_byte_i;
    assign o_byte_q = r_byte_q;

endmodule

`default_nettype wire

// ===== sv/iq_dc_blocker_byte_converter.sv =====
// I/Q DC blocker with word or byte output. Takes one item (a signed 16-bit
// I/Q pair) per clock cycle unless the output stalls; each item is
// registered in the lane stage, then in the output stage. The rate is set
// by the per-lane estimate update (subtract, multiply by 131, add), which
// is combinational so the next item sees the new estimate. Register 0 turns
// DC removal on (reset) or off; writing 0 zeroes both estimates. Register 1
// selects 16-bit words (1) or offset-binary bytes (0, reset); the unused
// form reads zero. Write the registers only while no item is in flight.
// Depends on iqdcb_pkg, iqdcb_lane, iqdcb_out and the assertion macro header.
`default_nettype none

`include "iq_dc_blocker_byte_converter_macros.svh"

module iq_dc_blocker_byte_converter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_in_i,
    input  wire logic signed [15:0] i_in_q,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_word_i,
    output logic signed [15:0]      o_word_q,
    output logic [7:0]              o_byte_i,
    output logic [7:0]              o_byte_q,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [0:0]         i_cfg_data
);

    logic r_enable;
    logic r_wide;
    logic r_s1_valid;

    logic accept;
    logic s1_move;
    logic out_space;
    logic clear;
    iqdcb_pkg::t_lane_ctl lane_ctl;
    logic signed [15:0] corr_i;
    logic signed [15:0] corr_q;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_wide   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iqdcb_pkg::CFG_DC_EN: r_enable <= i_cfg_data[0];
                iqdcb_pkg::CFG_WIDE:  r_wide   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign clear = i_cfg_we && (i_cfg_index == iqdcb_pkg::CFG_DC_EN) && !i_cfg_data[0];

    // Handshake: take an item whenever the correction stage is empty or can move on
    assign s1_move = r_s1_valid && out_space;
    assign o_ready = !r_s1_valid || out_space;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        lane_ctl.load   = accept;
        lane_ctl.enable = r_enable;
        lane_ctl.clear  = clear;
    end

    // In-phase and quadrature lanes
    iqdcb_lane u_lane_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_i),
        .o_corr   (corr_i)
    );

    iqdcb_lane u_lane_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_q),
        .o_corr   (corr_q)
    );

    // Merge both lanes into the output item
    iqdcb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_move),
        .i_wide   (r_wide),
        .i_corr_i (corr_i),
        .i_corr_q (corr_q),
        .i_ready  (i_ready),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .o_word_i (o_word_i),
        .o_word_q (o_word_q),
        .o_byte_i (o_byte_i),
        .o_byte_q (o_byte_q)
    );

    `IQDCB_ASSERT_SAME(a_ready_stall, !o_ready, r_s1_valid,
        "input stalled with empty stage")
    `IQDCB_ASSERT_SAME(a_out_from_stage, $rose(o_valid), $past(r_s1_valid),
        "output item from nowhere")
    `IQDCB_ASSERT_SAME(a_wide_bytes_zero, o_valid && r_wide,
        (o_byte_i == 8'h00) && (o_byte_q == 8'h00), "bytes not zero in word mode")
    `IQDCB_ASSERT_SAME(a_byte_words_zero, o_valid && !r_wide,
        (o_word_i == 16'sh0000) && (o_word_q == 16'sh0000), "words not zero in byte mode")
    `IQDCB_ASSERT_NEXT(a_move_fills_out, s1_move, o_valid, "moved item not shown")

endmodule

`default_nettype wire

// ===== test/tb_iq_dc_blocker_byte_converter.sv =====
// Self-checking testbench for the I/Q DC blocker with word or byte output.
// Depends on iqdcb_pkg and the iq_dc_blocker_byte_converter top level.
`timescale 1ns / 100ps

module tb_iq_dc_blocker_byte_converter;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
    } t_pair;

    typedef struct packed {
        logic signed [15:0] word_i;
        logic signed [15:0] word_q;
        logic [7:0]         byte_i;
        logic [7:0]         byte_q;
    } t_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_in_i      = '0;
    logic signed [15:0] i_in_q      = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic signed [15:0] o_word_i;
    logic signed [15:0] o_word_q;
    logic [7:0]         o_byte_i;
    logic [7:0]         o_byte_q;
    logic               i_cfg_we    = 1'b0;
    logic [0:0]         i_cfg_index = '0;
    logic [0:0]         i_cfg_data  = '0;

    // Pairs waiting to be driven and corrected pairs waiting to come out
    t_pair   pending_pairs[$];
    t_result corrected_pairs[$];

    // Mirror of the block's registers and DC estimates
    logic               dc_on      = 1'b1;
    logic               wide_mode  = 1'b0;
    logic signed [31:0] dc_level_i = '0;
    logic signed [31:0] dc_level_q = '0;

    logic gaps_on        = 1'b1;
    logic item_taken     = 1'b0;
    int   mismatch_count = 0;
    int   stuck_cycles   = 0;

    iq_dc_blocker_byte_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_i      (i_in_i),
        .i_in_q      (i_in_q),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word_i    (o_word_i),
        .o_word_q    (o_word_q),
        .o_byte_i    (o_byte_i),
        .o_byte_q    (o_byte_q),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Subtract the running average from one sample and advance the average
    function automatic logic signed [15:0] remove_dc(input logic signed [15:0] x,
                                                     inout logic signed [31:0] avg);
        logic signed [63:0] xq;
        logic signed [63:0] step;
        logic signed [63:0] upd;
        logic signed [63:0] resid;
        logic signed [63:0] c;
        xq = x;
        xq = xq <<< 16;
        step = (xq - avg) * 64'sd131;
        // arithmetic shift rounds the step towards minus infinity
        upd = avg + (step >>> 16);
        avg = upd[31:0];
        resid = xq - upd;
        // truncate towards zero
        if (resid >= 0)
            c = resid >>> 16;
        else
            c = -((-resid) >>> 16);
        if (c > 64'sd32767)
            return 16'sh7fff;
        if (c < -64'sd32768)
            return 16'sh8000;
        return c[15:0];
    endfunction

    function automatic t_result correct_pair(input logic signed [15:0] in_i,
                                             input logic signed [15:0] in_q);
        t_result            r;
        logic signed [15:0] ci;
        logic signed [15:0] cq;
        ci = in_i;
        cq = in_q;
        if (dc_on) begin
            ci = remove_dc(ci, dc_level_i);
            cq = remove_dc(cq, dc_level_q);
        end
        r = '0;
        if (wide_mode) begin
            r.word_i = ci;
            r.word_q = cq;
        end else begin
            r.byte_i = ci[15:8] ^ iqdcb_pkg::BYTE_OFFSET;
            r.byte_q = cq[15:8] ^ iqdcb_pkg::BYTE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic take_gap();
        return gaps_on && ($urandom_range(99) < 11);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Hold until every pair is through and the pipeline has settled
    task automatic wait_idle();
        while (pending_pairs.size() != 0 || i_valid || corrected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input iqdcb_pkg::t_cfg_idx idx, input logic val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == iqdcb_pkg::CFG_DC_EN) begin
            dc_on = val;
            // switching removal off zeroes both averages
            if (!val) begin
                dc_level_i = '0;
                dc_level_q = '0;
            end
        end else begin
            wide_mode = val;
        end
    endtask

    task automatic queue_pair(input logic signed [15:0] pi, input logic signed [15:0] pq);
        t_pair p;
        p.i = pi;
        p.q = pq;
        pending_pairs.push_back(p);
    endtask

    // Full-scale corners, zero, the sign boundary and the byte boundary
    task automatic queue_corner_pairs();
        queue_pair(16'sh7fff, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7fff);
        queue_pair(16'sh0000, 16'sh0000);
        queue_pair(-16'sd1, 16'sd1);
        queue_pair(16'sd255, -16'sd256);
        queue_pair(-16'sd129, 16'sd128);
    endtask

    // A DC offset with noise on top, and a share of full-range samples
    task automatic queue_dc_run(input int count, input int level, input int spread,
                                input int wild_pct);
        logic signed [15:0] pi;
        logic signed [15:0] pq;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < wild_pct) begin
                pi = 16'($urandom);
                pq = 16'($urandom);
            end else begin
                pi = clamp16(level + int'($urandom_range(2 * spread)) - spread);
                pq = clamp16(-level / 2 + int'($urandom_range(2 * spread)) - spread);
            end
            queue_pair(pi, pq);
        end
    endtask

    // Drive the next pair at the falling edge, or idle
    always @(negedge i_clk) begin
        t_pair p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_pairs.size() != 0 && !take_gap()) begin
                p = pending_pairs.pop_front();
                i_in_i  <= p.i;
                i_in_q  <= p.q;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_ready <= !take_gap();
    end

    // Predict on acceptance, check results, watch for a hang
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            stuck_cycles++;
            if (i_valid && o_ready) begin
                corrected_pairs.push_back(correct_pair(i_in_i, i_in_q));
                item_taken   = 1'b1;
                stuck_cycles = 0;
            end
            if (o_valid && i_ready) begin
                stuck_cycles = 0;
                if (corrected_pairs.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = corrected_pairs.pop_front();
                    if (o_word_i !== want.word_i)
                        report_mismatch($sformatf("word_i %0d, expected %0d",
                                                  o_word_i, want.word_i));
                    if (o_word_q !== want.word_q)
                        report_mismatch($sformatf("word_q %0d, expected %0d",
                                                  o_word_q, want.word_q));
                    if (o_byte_i !== want.byte_i)
                        report_mismatch($sformatf("byte_i %0d, expected %0d",
                                                  o_byte_i, want.byte_i));
                    if (o_byte_q !== want.byte_q)
                        report_mismatch($sformatf("byte_q %0d, expected %0d",
                                                  o_byte_q, want.byte_q));
                end
            end
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corners in every combination of removal and output form
        queue_corner_pairs();
        write_reg(iqdcb_pkg::CFG_WIDE, 1'b1);
        queue_corner_pairs();
        write_reg(iqdcb_pkg::CFG_DC_EN, 1'b0);
        queue_corner_pairs();
        write_reg(iqdcb_pkg::CFG_WIDE, 1'b0);
        queue_corner_pairs();

        // Removal back on in word form: offsets with noise
        write_reg(iqdcb_pkg::CFG_DC_EN, 1'b1);
        write_reg(iqdcb_pkg::CFG_WIDE, 1'b1);
        queue_dc_run(140, int'($urandom_range(40000)) - 20000, 3000, 20);

        // Enable rewritten while on keeps the averages; byte form, no gaps
        write_reg(iqdcb_pkg::CFG_DC_EN, 1'b1);
        write_reg(iqdcb_pkg::CFG_WIDE, 1'b0);
        gaps_on = 1'b0;
        queue_dc_run(100, int'($urandom_range(40000)) - 20000, 1500, 15);
        wait_idle();
        gaps_on = 1'b1;

        // Pass-through with full-range samples in both forms
        write_reg(iqdcb_pkg::CFG_DC_EN, 1'b0);
        queue_dc_run(60, 0, 0, 100);
        write_reg(iqdcb_pkg::CFG_WIDE, 1'b1);
        queue_dc_run(30, 0, 0, 100);

        // Drive the average towards full scale, then swing to the far rail
        write_reg(iqdcb_pkg::CFG_DC_EN, 1'b1);
        queue_dc_run(120, 32000, 700, 5);
        queue_dc_run(10, -32768, 0, 0);
        queue_dc_run(60, -32000, 700, 5);
        queue_dc_run(10, 32767, 0, 0);

        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
